// File: src/tab_pkg.sv
package tab_pkg;

  // Field widths of the channels.
  localparam int ADDRESS_W = 16;
  localparam int LENGTH_W  = 16;

  // Default sizes of the bitmap.
  localparam int ADDRESS_BITS_DEF = 16;
  localparam int WORD_BITS_DEF    = 64;

  // Operation codes.
  localparam logic OP_MARK  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // take a new item and read its first word
    logic rd_word;    // read the current word of a run
    logic wr_mark;    // write the current word with the run mask and advance
    logic wr_clear;   // write zeros to the current word and advance
    logic out_load;   // capture the queried bit into the result register
  } tab_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_chunk; // the current word finishes the run
    logic last_word;  // the clearing pass is at the top word
  } tab_status_t;

endpackage

// File: src/tab_in_if.sv
interface tab_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [tab_pkg::ADDRESS_W-1:0] address;
  logic [tab_pkg::LENGTH_W-1:0]  length;

  modport source (output valid, operation, address, length, input ready);
  modport sink   (input valid, operation, address, length, output ready);
endinterface

// File: src/tab_out_if.sv
interface tab_out_if;
  logic valid;
  logic ready;
  logic touched;
  logic never_stored;

  modport source (output valid, touched, never_stored, input ready);
  modport sink   (input valid, touched, never_stored, output ready);
endinterface

// File: src/touched_address_bitmap_top.sv
// Touched-address bitmap: one bit per address of an emulated memory of
// 2**ADDRESS_BITS addresses, held in an on-chip RAM of words.
// The input channel carries items. A mark item (operation 0) sets the bit of
// every address from address through address + length - 1, wrapping at the
// top of the space; it gives no result, and a length of zero marks nothing.
// A query item (operation 1) gives one result transfer on the output channel:
// touched is 1 if the address was ever marked, never_stored is its inverse.
// After reset the block sweeps the RAM to zero, one word per cycle; ready stays
// low during that sweep. Items are handled one at a time. A query reads its word
// when it is taken and its bit is captured into the result register in the
// query step once that register is free; the block then returns to idle for the
// next item. A mark covering k words does one RAM read and one RAM write per
// word, since the single RAM port pair serializes the read-modify-write of each
// word. The result sits in an output register: while the receiver stalls, the
// block still takes mark items and holds the result; a further query waits
// until the pending result has been transferred.
module touched_address_bitmap_top #(
  parameter int ADDRESS_BITS = tab_pkg::ADDRESS_BITS_DEF,
  parameter int WORD_BITS    = tab_pkg::WORD_BITS_DEF
) (
  input logic      clk_i,
  input logic      rst_ni,
  tab_in_if.sink   in_i,
  tab_out_if.source out_o
);
  import tab_pkg::*;

  tab_cmd_t    cmd;
  tab_status_t st;

  // Sequencer: owns the state, the handshakes and the result valid flag.
  tab_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_op_i     (in_i.operation),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd),
    .st_i        (st)
  );

  // Bitmap RAM, run walker and result register.
  tab_datapath #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .WORD_BITS    (WORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_address_i   (in_i.address),
    .in_length_i    (in_i.length),
    .cmd_i          (cmd),
    .st_o           (st),
    .touched_o      (out_o.touched),
    .never_stored_o (out_o.never_stored)
  );

endmodule

// File: src/tab_datapath.sv
module tab_datapath #(
  parameter int ADDRESS_BITS = tab_pkg::ADDRESS_BITS_DEF,
  parameter int WORD_BITS    = tab_pkg::WORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [tab_pkg::ADDRESS_W-1:0] in_address_i,
  input  logic [tab_pkg::LENGTH_W-1:0]  in_length_i,
  input  tab_pkg::tab_cmd_t             cmd_i,
  output tab_pkg::tab_status_t          st_o,
  output logic                          touched_o,
  output logic                          never_stored_o
);
  import tab_pkg::*;

  // Each memory word holds the largest power of two of bits that fits in WORD_BITS.
  localparam int SLICE_BITS = 2 ** ($clog2(WORD_BITS + 1) - 1);
  localparam int OFF_W      = $clog2(SLICE_BITS);
  localparam int IDX_W      = ADDRESS_BITS - OFF_W;
  localparam int DEPTH      = 2 ** IDX_W;
  localparam int REM_W      = LENGTH_W + 1;

  logic [SLICE_BITS-1:0]   mem [DEPTH];
  logic [SLICE_BITS-1:0]   rdata_q;
  logic [IDX_W-1:0]        word_q, word_d;
  logic [OFF_W-1:0]        bit_q, bit_d;
  logic [REM_W-1:0]        rem_q, rem_d;
  logic                    touched_q;
  logic [ADDRESS_BITS-1:0] addr;
  logic [IDX_W-1:0]        raddr;
  logic                    re;
  logic                    we;
  logic [SLICE_BITS-1:0]   wdata;
  logic [SLICE_BITS-1:0]   mask;
  logic [OFF_W:0]          room;
  logic                    last_chunk;

  assign addr  = ADDRESS_BITS'(in_address_i);
  assign raddr = cmd_i.load ? addr[ADDRESS_BITS-1:OFF_W] : word_q;
  assign re    = cmd_i.load | cmd_i.rd_word;
  assign we    = cmd_i.wr_mark | cmd_i.wr_clear;

  // Bits of the current word covered by the rest of the run.
  always_comb begin
    for (int i = 0; i < SLICE_BITS; i++) begin
      mask[i] = (REM_W'(i) >= REM_W'(bit_q)) && ((REM_W'(i) - REM_W'(bit_q)) < rem_q);
    end
  end

  assign room       = (OFF_W + 1)'(SLICE_BITS) - (OFF_W + 1)'(bit_q);
  assign last_chunk = rem_q <= REM_W'(room);
  assign wdata      = cmd_i.wr_clear ? '0 : (rdata_q | mask);

  always_comb begin
    word_d = word_q;
    bit_d  = bit_q;
    rem_d  = rem_q;
    if (cmd_i.load) begin
      word_d = addr[ADDRESS_BITS-1:OFF_W];
      bit_d  = addr[OFF_W-1:0];
      rem_d  = REM_W'(in_length_i);
    end else if (cmd_i.wr_mark) begin
      word_d = word_q + 1'b1;
      bit_d  = '0;
      rem_d  = last_chunk ? '0 : rem_q - REM_W'(room);
    end else if (cmd_i.wr_clear) begin
      word_d = word_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
      bit_q  <= '0;
      rem_q  <= '0;
    end else begin
      word_q <= word_d;
      bit_q  <= bit_d;
      rem_q  <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[word_q] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      touched_q <= rdata_q[bit_q];
    end
  end

  assign touched_o      = touched_q;
  assign never_stored_o = ~touched_q;

  assign st_o.last_chunk = last_chunk;
  assign st_o.last_word  = &word_q;

  // A word of a run that is not the last one leaves less of the run to do.
  a_rem_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_mark && !last_chunk) |=> (rem_q < $past(rem_q)))
    else $error("run length did not shrink");

  // The last word of a run leaves nothing to mark.
  a_rem_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_mark && last_chunk) |=> (rem_q == '0))
    else $error("run not finished after its last word");

  // A continuing word of a run is always read at bit offset zero.
  a_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_word |-> (bit_q == '0))
    else $error("continuing word does not start at bit zero");

endmodule

// File: src/tab_controller.sv
module tab_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_op_i,
  output logic                 in_ready_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output tab_pkg::tab_cmd_t    cmd_o,
  input  tab_pkg::tab_status_t st_i
);
  import tab_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR   = 5'b00001,
    S_IDLE    = 5'b00010,
    S_MARK_RD = 5'b00100,
    S_MARK_WR = 5'b01000,
    S_QUERY   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.wr_clear = 1'b1;
        if (st_i.last_word) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = (in_op_i == OP_QUERY) ? S_QUERY : S_MARK_WR;
        end
      end
      S_MARK_RD: begin
        cmd_o.rd_word = 1'b1;
        state_d       = S_MARK_WR;
      end
      S_MARK_WR: begin
        cmd_o.wr_mark = 1'b1;
        state_d       = st_i.last_chunk ? S_IDLE : S_MARK_RD;
      end
      S_QUERY: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // An accepted query goes straight to the result step.
  a_query_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_op_i == OP_QUERY) |=> (state_q == S_QUERY))
    else $error("query did not reach the result step");

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // A result is produced only by a query.
  a_result_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_QUERY))
    else $error("result without a query");

endmodule
